// ----- rtl/cso_pkg.sv -----
// Package for the cursor sprite overlay: field widths, opcode and register codes,
// the arrow sprite pattern and the clamp helper. No dependencies.
package cso_pkg;

    localparam int CSO_POS_W   = 10;
    localparam int CSO_DIM_W   = 11;
    localparam int CSO_COLOR_W = 8;
    localparam int CSO_OP_W    = 3;
    localparam int CSO_CFG_IW  = 2;

    localparam int CSO_SPRITE_WIDTH  = 17;
    localparam int CSO_SPRITE_HEIGHT = 22;
    localparam int CSO_MAX_FRAME_DIM = 1024;

    localparam int CSO_ROM_CELLS = 374;
    localparam int CSO_ROM_AW    = 9;

    localparam logic [CSO_DIM_W-1:0] CSO_STEP       = CSO_DIM_W'(6);
    localparam logic [CSO_DIM_W-1:0] CSO_COL_MARGIN = CSO_DIM_W'(8);
    localparam logic [CSO_DIM_W-1:0] CSO_ROW_MARGIN = CSO_DIM_W'(11);

    localparam logic [CSO_DIM_W-1:0] CSO_FW_RESET = CSO_DIM_W'(240);
    localparam logic [CSO_DIM_W-1:0] CSO_FH_RESET = CSO_DIM_W'(320);

    // Highest cursor position a move may reach, whatever the frame size.
    localparam int CSO_CAP_INT = (CSO_MAX_FRAME_DIM - 1 < 1023) ? CSO_MAX_FRAME_DIM - 1 : 1023;
    localparam logic [CSO_DIM_W-1:0] CSO_CAP = CSO_DIM_W'(CSO_CAP_INT);

    localparam logic [CSO_COLOR_W-1:0] CSO_COLOR_MAX = 8'hFF;

    typedef enum logic [CSO_OP_W-1:0] {
        OP_PIXEL = 3'd0,
        OP_UP    = 3'd1,
        OP_DOWN  = 3'd2,
        OP_LEFT  = 3'd3,
        OP_RIGHT = 3'd4
    } t_opcode;

    typedef enum logic [CSO_CFG_IW-1:0] {
        CFG_CURSOR_ENABLE = 2'd0,
        CFG_FRAME_WIDTH   = 2'd1,
        CFG_FRAME_HEIGHT  = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CODE_CLEAR = 2'd0,
        CODE_BLACK = 2'd1,
        CODE_WHITE = 2'd2,
        CODE_SPARE = 2'd3
    } t_sprite_code;

    typedef logic [1:0] t_code;

    // Arrow pattern, row by row, CSO_SPRITE_WIDTH cells to a row.
    localparam t_code CSO_ARROW [CSO_ROM_CELLS] = '{
        2'd0,2'd0,2'd0,2'd0,2'd0,2'd1,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
        2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
        2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
        2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
        2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd1,2'd1,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
        2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd1,2'd2,2'd2,2'd1,2'd1,2'd1,2'd0,2'd0,2'd0,2'd0,
        2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd1,2'd2,2'd2,2'd1,2'd2,2'd2,2'd1,2'd1,2'd0,2'd0,
        2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd1,2'd2,2'd2,2'd1,2'd2,2'd2,2'd1,2'd2,2'd1,2'd0,
        2'd1,2'd1,2'd1,2'd0,2'd1,2'd2,2'd2,2'd1,2'd2,2'd2,2'd1,2'd2,2'd2,2'd1,2'd2,2'd2,2'd1,
        2'd1,2'd2,2'd2,2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd2,2'd1,
        2'd1,2'd2,2'd2,2'd2,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,
        2'd0,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,
        2'd0,2'd0,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,
        2'd0,2'd0,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,
        2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,
        2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0,
        2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0,
        2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0,
        2'd0,2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0,
        2'd0,2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0,
        2'd0,2'd0,2'd0,2'd0,2'd0,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd0,2'd0,
        2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0
    };

    // Highest position a move toward the high side may reach for a given frame size.
    function automatic logic [CSO_POS_W-1:0] cso_high_clamp(
        input logic [CSO_DIM_W-1:0] dim,
        input logic [CSO_DIM_W-1:0] margin
    );
        logic [CSO_DIM_W-1:0] lim;
        lim = (dim > margin) ? dim - margin : '0;
        if (lim > CSO_CAP) begin
            lim = CSO_CAP;
        end
        return lim[CSO_POS_W-1:0];
    endfunction

endpackage

// ----- rtl/cso_pix_in_if.sv -----
// Input channel of the cursor overlay: one event item per handshake.
// Depends on cso_pkg for the field widths.
interface cso_pix_in_if
    import cso_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CSO_OP_W-1:0]    opcode;
    logic [CSO_POS_W-1:0]   pixel_x;
    logic [CSO_POS_W-1:0]   pixel_y;
    logic [CSO_COLOR_W-1:0] red_in;
    logic [CSO_COLOR_W-1:0] green_in;
    logic [CSO_COLOR_W-1:0] blue_in;

    modport source(output valid, opcode, pixel_x, pixel_y, red_in, green_in, blue_in,
                   input ready);
    modport sink(input valid, opcode, pixel_x, pixel_y, red_in, green_in, blue_in,
                 output ready);
endinterface

// ----- rtl/cso_pix_out_if.sv -----
// Output channel of the cursor overlay: one result item per handshake.
// Depends on cso_pkg for the field widths.
interface cso_pix_out_if
    import cso_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CSO_COLOR_W-1:0] red_out;
    logic [CSO_COLOR_W-1:0] green_out;
    logic [CSO_COLOR_W-1:0] blue_out;
    logic [CSO_POS_W-1:0]   cursor_col;
    logic [CSO_POS_W-1:0]   cursor_row;

    modport source(output valid, red_out, green_out, blue_out, cursor_col, cursor_row,
                   input ready);
    modport sink(input valid, red_out, green_out, blue_out, cursor_col, cursor_row,
                 output ready);
endinterface

// ----- rtl/cso_cfg_if.sv -----
// Configuration write channel of the cursor overlay: register index and data.
// Depends on cso_pkg for the field widths.
interface cso_cfg_if
    import cso_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CSO_CFG_IW-1:0] index;
    logic [CSO_DIM_W-1:0]  data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/cursor_sprite_overlay_core.sv -----
// Hardware cursor over an RGB888 pixel stream. Each input item is either a pixel
// (opcode 0) or a cursor move (up, down, left, right in steps of 6, clamped at 0 and at
// frame width minus 8 or frame height minus 11). A pixel that falls inside the 17x22 arrow
// sprite whose top left corner sits at the cursor is forced black or white where the sprite
// says so; elsewhere it passes through. Moves and overlay act only while cursor_enable is 1.
// Every item returns exactly one result carrying the colour (zero for moves and unused
// opcodes) and the cursor position after the item. The block takes one item per clock
// unless output backpressure stalls it; stage 1 holds the registered read of the sprite ROM.
// An output register and a stall of the whole two-stage pipe on output backpressure keep
// items flowing as long as the sink takes them. Configuration writes are always accepted;
// an index beyond the three registers is ignored. Depends on cso_pkg and the three channel
// interfaces.
module cursor_sprite_overlay_core
    import cso_pkg::*;
#(
    parameter int SPRITE_WIDTH  = CSO_SPRITE_WIDTH,
    parameter int SPRITE_HEIGHT = CSO_SPRITE_HEIGHT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cso_pix_in_if.sink    i_pix,
    cso_pix_out_if.source o_pix,
    cso_cfg_if.sink       i_cfg
);

    localparam int IDX_W = $clog2(SPRITE_WIDTH * SPRITE_HEIGHT + 1);
    localparam logic [CSO_POS_W-1:0] SW_L = CSO_POS_W'(SPRITE_WIDTH);
    localparam logic [CSO_POS_W-1:0] SH_L = CSO_POS_W'(SPRITE_HEIGHT);

    // Configuration registers, plus the move clamps derived from the frame size.
    logic                 r_enable;
    logic [CSO_DIM_W-1:0] r_fw;
    logic [CSO_DIM_W-1:0] r_fh;
    logic [CSO_POS_W-1:0] r_xlim;
    logic [CSO_POS_W-1:0] r_ylim;

    // Cursor position: always reflects every item accepted so far.
    logic [CSO_POS_W-1:0] r_cx;
    logic [CSO_POS_W-1:0] r_cy;
    logic [CSO_POS_W-1:0] n_cx;
    logic [CSO_POS_W-1:0] n_cy;

    // Stage 1: sprite ROM data plus what the colour selection needs.
    logic                   r_s1_valid;
    logic                   r_s1_pixel;
    logic                   r_s1_hit;
    t_code                  r_rom_code;
    logic [CSO_COLOR_W-1:0] r_s1_r;
    logic [CSO_COLOR_W-1:0] r_s1_g;
    logic [CSO_COLOR_W-1:0] r_s1_b;
    logic [CSO_POS_W-1:0]   r_s1_cx;
    logic [CSO_POS_W-1:0]   r_s1_cy;

    // Output register.
    logic                   r_o_valid;
    logic [CSO_COLOR_W-1:0] r_o_r;
    logic [CSO_COLOR_W-1:0] r_o_g;
    logic [CSO_COLOR_W-1:0] r_o_b;
    logic [CSO_POS_W-1:0]   r_o_cx;
    logic [CSO_POS_W-1:0]   r_o_cy;

    logic in_accept;
    logic s1_advance;
    logic cfg_accept;

    logic [CSO_POS_W-1:0]  dx;
    logic [CSO_POS_W-1:0]  dy;
    logic [IDX_W-1:0]      idx;
    logic                  hit;
    logic [CSO_DIM_W-1:0]  sum_x;
    logic [CSO_DIM_W-1:0]  sum_y;
    t_sprite_code          code;
    logic [CSO_COLOR_W-1:0] n_r;
    logic [CSO_COLOR_W-1:0] n_g;
    logic [CSO_COLOR_W-1:0] n_b;

    // Handshakes. The output register frees when its item is taken, stage 1 then moves
    // into it, and a new item enters stage 1 whenever stage 1 is empty or moving on.
    assign s1_advance  = r_s1_valid && (!r_o_valid || o_pix.ready);
    assign i_pix.ready = !r_s1_valid || s1_advance;
    assign in_accept   = i_pix.valid && i_pix.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_accept  = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_fw     <= CSO_FW_RESET;
            r_fh     <= CSO_FH_RESET;
            r_xlim   <= cso_high_clamp(CSO_FW_RESET, CSO_COL_MARGIN);
            r_ylim   <= cso_high_clamp(CSO_FH_RESET, CSO_ROW_MARGIN);
        end else if (cfg_accept) begin
            unique case (i_cfg.index)
                CFG_CURSOR_ENABLE: r_enable <= i_cfg.data[0];
                CFG_FRAME_WIDTH: begin
                    r_fw   <= i_cfg.data;
                    r_xlim <= cso_high_clamp(i_cfg.data, CSO_COL_MARGIN);
                end
                CFG_FRAME_HEIGHT: begin
                    r_fh   <= i_cfg.data;
                    r_ylim <= cso_high_clamp(i_cfg.data, CSO_ROW_MARGIN);
                end
                default: ;
            endcase
        end
    end

    // Cursor moves. A high-side move lands on the clamp when the step would reach or
    // pass it, which also pulls back a cursor left beyond a shrunken frame.
    always_comb begin
        n_cx  = r_cx;
        n_cy  = r_cy;
        sum_x = {1'b0, r_cx} + CSO_STEP;
        sum_y = {1'b0, r_cy} + CSO_STEP;
        if (r_enable) begin
            case (i_pix.opcode)
                OP_UP:    n_cy = ({1'b0, r_cy} < CSO_STEP) ? '0 : r_cy - CSO_STEP[CSO_POS_W-1:0];
                OP_DOWN:  n_cy = (sum_y >= {1'b0, r_ylim}) ? r_ylim : sum_y[CSO_POS_W-1:0];
                OP_LEFT:  n_cx = ({1'b0, r_cx} < CSO_STEP) ? '0 : r_cx - CSO_STEP[CSO_POS_W-1:0];
                OP_RIGHT: n_cx = (sum_x >= {1'b0, r_xlim}) ? r_xlim : sum_x[CSO_POS_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
        end else if (in_accept) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
        end
    end

    // Sprite hit test against the cursor as it stands when the pixel arrives. The cell
    // index is only meaningful on a hit, so its truncation elsewhere does no harm.
    always_comb begin
        dx  = i_pix.pixel_x - r_cx;
        dy  = i_pix.pixel_y - r_cy;
        idx = IDX_W'(dy) * IDX_W'(SPRITE_WIDTH) + IDX_W'(dx);
        hit = r_enable
            && (i_pix.pixel_x >= r_cx) && (i_pix.pixel_y >= r_cy)
            && ({1'b0, i_pix.pixel_x} < r_fw) && ({1'b0, i_pix.pixel_y} < r_fh)
            && (dx < SW_L) && (dy < SH_L)
            && (32'(idx) < CSO_ROM_CELLS);
    end

    // Sprite ROM with registered read data; it holds while the pipe stalls.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rom_code <= hit ? CSO_ARROW[CSO_ROM_AW'(idx)] : CODE_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pixel <= (i_pix.opcode == OP_PIXEL);
            r_s1_hit   <= hit;
            r_s1_r     <= i_pix.red_in;
            r_s1_g     <= i_pix.green_in;
            r_s1_b     <= i_pix.blue_in;
            r_s1_cx    <= n_cx;
            r_s1_cy    <= n_cy;
        end
    end

    // Colour selection: moves and unused opcodes give black, code 1 forces black,
    // code 2 forces white, anything else lets the pixel through.
    always_comb begin
        code = r_s1_hit ? t_sprite_code'(r_rom_code) : CODE_CLEAR;
        n_r  = r_s1_r;
        n_g  = r_s1_g;
        n_b  = r_s1_b;
        if (!r_s1_pixel) begin
            n_r = '0;
            n_g = '0;
            n_b = '0;
        end else begin
            case (code)
                CODE_BLACK: begin
                    n_r = '0;
                    n_g = '0;
                    n_b = '0;
                end
                CODE_WHITE: begin
                    n_r = CSO_COLOR_MAX;
                    n_g = CSO_COLOR_MAX;
                    n_b = CSO_COLOR_MAX;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (!r_o_valid || o_pix.ready) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_o_r  <= n_r;
            r_o_g  <= n_g;
            r_o_b  <= n_b;
            r_o_cx <= r_s1_cx;
            r_o_cy <= r_s1_cy;
        end
    end

    assign o_pix.valid      = r_o_valid;
    assign o_pix.red_out    = r_o_r;
    assign o_pix.green_out  = r_o_g;
    assign o_pix.blue_out   = r_o_b;
    assign o_pix.cursor_col = r_o_cx;
    assign o_pix.cursor_row = r_o_cy;

endmodule

// ----- tb/tb_cursor_sprite_overlay_core.sv -----
// Self-checking testbench for cursor_sprite_overlay_core: directed and random event
// streams, random idling on both channels, and a scoreboard that predicts every result.
// Depends on cso_pkg and the three channel interfaces of the RTL.
module tb_cursor_sprite_overlay_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cso_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 4;
    // A result passes stage 1 and the output register; this pause covers that with margin.
    localparam int DRAIN_CYCLES  = 6;
    // Longest run of cycles without any accepted item before the run is declared hung.
    // Idle and stall bursts are much shorter, so this is far beyond a correct run.
    localparam int HANG_LIMIT    = 2000;
    localparam int RANDOM_EVENTS = 1400;
    // Events at the end of the run that are sent with no idling on either side.
    localparam int TAIL_EVENTS   = 150;

    localparam int MOVE_STEP     = 6;
    localparam int COL_MARGIN    = 8;
    localparam int ROW_MARGIN    = 11;
    localparam int POS_MAX       = 2 ** CSO_POS_W - 1;
    localparam int WIDTH_AT_RST  = 240;
    localparam int HEIGHT_AT_RST = 320;
    localparam logic [CSO_COLOR_W-1:0] COLOR_FULL = 8'hFF;
    // The register index that the block has no register for; writes to it are dropped.
    localparam logic [CSO_CFG_IW-1:0] CFG_UNUSED_INDEX = 2'd3;
    // The lowest and the highest opcode that the block does not use.
    localparam logic [CSO_OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [CSO_OP_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [CSO_OP_W-1:0]    opcode;
        logic [CSO_POS_W-1:0]   pixel_x;
        logic [CSO_POS_W-1:0]   pixel_y;
        logic [CSO_COLOR_W-1:0] red_in;
        logic [CSO_COLOR_W-1:0] green_in;
        logic [CSO_COLOR_W-1:0] blue_in;
    } pix_event_t;

    typedef struct packed {
        logic [CSO_COLOR_W-1:0] red_out;
        logic [CSO_COLOR_W-1:0] green_out;
        logic [CSO_COLOR_W-1:0] blue_out;
        logic [CSO_POS_W-1:0]   cursor_col;
        logic [CSO_POS_W-1:0]   cursor_row;
    } pix_result_t;

    typedef struct packed {
        logic [CSO_CFG_IW-1:0] index;
        logic [CSO_DIM_W-1:0]  data;
    } cfg_write_t;

    // Scoreboard: keeps its own copy of the cursor, the frame size and the enable, works
    // out the result of every accepted event and compares the block's results in order.
    class overlay_scoreboard;
        bit                   enabled;
        logic [CSO_DIM_W-1:0] frame_w;
        logic [CSO_DIM_W-1:0] frame_h;
        int                   cur_col;
        int                   cur_row;
        t_sprite_code         arrow [CSO_SPRITE_HEIGHT][CSO_SPRITE_WIDTH];
        pix_result_t          pending_pixels [$];
        int                   errors;

        function new();
            string rows [CSO_SPRITE_HEIGHT];
            // The arrow, one string per sprite row: 0 clear, 1 black, 2 white.
            rows = '{
                "00000110000000000",
                "00001221000000000",
                "00001221000000000",
                "00001221000000000",
                "00001221110000000",
                "00001221221110000",
                "00001221221221100",
                "00001221221221210",
                "11101221221221221",
                "12211222222221221",
                "12221222222222221",
                "01222222222222221",
                "00122222222222221",
                "00122222222222221",
                "00012222222222221",
                "00012222222222210",
                "00001222222222210",
                "00001222222222210",
                "00000122222222100",
                "00000122222222100",
                "00000111111111100",
                "00000000000000000"
            };
            foreach (arrow[r, c]) begin
                arrow[r][c] = t_sprite_code'(2'(rows[r].getc(c) - "0"));
            end
            enabled = 1'b0;
            frame_w = CSO_DIM_W'(WIDTH_AT_RST);
            frame_h = CSO_DIM_W'(HEIGHT_AT_RST);
            cur_col = 0;
            cur_row = 0;
            errors  = 0;
        endfunction

        function void write_reg(logic [CSO_CFG_IW-1:0] index, logic [CSO_DIM_W-1:0] data);
            case (index)
                CFG_CURSOR_ENABLE: enabled = data[0];
                CFG_FRAME_WIDTH:   frame_w = data;
                CFG_FRAME_HEIGHT:  frame_h = data;
                default: ;
            endcase
        endfunction

        // Farthest position a move toward the high side may reach.
        function int high_limit(logic [CSO_DIM_W-1:0] dim, int margin);
            int lim;
            int cap;
            cap = CSO_MAX_FRAME_DIM - 1;
            if (cap > POS_MAX) begin
                cap = POS_MAX;
            end
            lim = (int'(dim) > margin) ? int'(dim) - margin : 0;
            return (lim > cap) ? cap : lim;
        endfunction

        function int step_high(int pos, int lim);
            return (pos + MOVE_STEP >= lim) ? lim : pos + MOVE_STEP;
        endfunction

        function int step_low(int pos);
            return (pos < MOVE_STEP) ? 0 : pos - MOVE_STEP;
        endfunction

        // Sprite cell under a pixel; clear outside the frame and outside the sprite box.
        function t_sprite_code cell_under(int px, int py);
            int dx;
            int dy;
            if (px < cur_col || py < cur_row) begin
                return CODE_CLEAR;
            end
            if (px >= int'(frame_w) || py >= int'(frame_h)) begin
                return CODE_CLEAR;
            end
            dx = px - cur_col;
            dy = py - cur_row;
            if (dx >= CSO_SPRITE_WIDTH || dy >= CSO_SPRITE_HEIGHT) begin
                return CODE_CLEAR;
            end
            return arrow[dy][dx];
        endfunction

        function pix_result_t overlay_event(pix_event_t ev);
            pix_result_t  res;
            t_sprite_code code;
            res = '0;
            if (ev.opcode == OP_PIXEL) begin
                code = enabled ? cell_under(int'(ev.pixel_x), int'(ev.pixel_y)) : CODE_CLEAR;
                case (code)
                    CODE_BLACK: ;
                    CODE_WHITE: begin
                        res.red_out   = COLOR_FULL;
                        res.green_out = COLOR_FULL;
                        res.blue_out  = COLOR_FULL;
                    end
                    default: begin
                        res.red_out   = ev.red_in;
                        res.green_out = ev.green_in;
                        res.blue_out  = ev.blue_in;
                    end
                endcase
            end else if (enabled) begin
                case (ev.opcode)
                    OP_UP:    cur_row = step_low(cur_row);
                    OP_DOWN:  cur_row = step_high(cur_row, high_limit(frame_h, ROW_MARGIN));
                    OP_LEFT:  cur_col = step_low(cur_col);
                    OP_RIGHT: cur_col = step_high(cur_col, high_limit(frame_w, COL_MARGIN));
                    default: ;
                endcase
            end
            res.cursor_col = CSO_POS_W'(cur_col);
            res.cursor_row = CSO_POS_W'(cur_row);
            return res;
        endfunction

        function void note_event(pix_event_t ev);
            pending_pixels.push_back(overlay_event(ev));
        endfunction

        function void compare_field(string field, logic [CSO_POS_W-1:0] want,
                                    logic [CSO_POS_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(pix_result_t got);
            pix_result_t want;
            if (pending_pixels.size() == 0) begin
                $error("result item with no event pending: col %0d row %0d",
                       got.cursor_col, got.cursor_row);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            compare_field("red_out",    want.red_out,    got.red_out);
            compare_field("green_out",  want.green_out,  got.green_out);
            compare_field("blue_out",   want.blue_out,   got.blue_out);
            compare_field("cursor_col", want.cursor_col, got.cursor_col);
            compare_field("cursor_row", want.cursor_row, got.cursor_row);
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    cso_pix_in_if  pix_in ();
    cso_pix_out_if pix_out ();
    cso_cfg_if     cfg_bus ();

    cursor_sprite_overlay_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .i_cfg   (cfg_bus)
    );

    overlay_scoreboard sb = new();

    // Idling controls, changed per phase by the stimulus process. In the tail of the run
    // neither side idles, so the block is also seen at its full rate.
    bit gaps_on    = 1'b0;
    bit stalls_on  = 1'b0;
    bit quiet_tail = 1'b0;
    int events_sent = 0;
    int quiet_cycles = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    // Every result item is checked at the rising edge where it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            sb.check_pixel('{red_out:    pix_out.red_out,
                             green_out:  pix_out.green_out,
                             blue_out:   pix_out.blue_out,
                             cursor_col: pix_out.cursor_col,
                             cursor_row: pix_out.cursor_row});
        end
    end

    // Hang detector: any accepted item on any channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stall bursts alternate with runs of ready, so that stalls land
    // on every stage of the pipe, including back to back with input gaps.
    initial begin
        pix_out.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (stalls_on && !quiet_tail && $urandom_range(0, 99) < 30) begin
                pix_out.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            pix_out.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
    end

    // Sends one event. Entered and left at a falling edge; valid stays high when the next
    // event follows at once, and drops only for an idle burst.
    task automatic send_event(input pix_event_t ev);
        if (gaps_on && !quiet_tail && $urandom_range(0, 99) < 20) begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.opcode   <= ev.opcode;
        pix_in.pixel_x  <= ev.pixel_x;
        pix_in.pixel_y  <= ev.pixel_y;
        pix_in.red_in   <= ev.red_in;
        pix_in.green_in <= ev.green_in;
        pix_in.blue_in  <= ev.blue_in;
        do @(posedge i_clk); while (!pix_in.ready);
        sb.note_event(ev);
        events_sent++;
        @(negedge i_clk);
    endtask

    // Stops input and waits until every expected result has come and the pipe is empty.
    // Entered and left at a falling edge.
    task automatic settle();
        pix_in.valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Writes a list of registers back to back, only ever while the block is idle.
    task automatic apply_config(input cfg_write_t writes [$]);
        foreach (writes[i]) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= writes[i].index;
            cfg_bus.data  <= writes[i].data;
            do @(posedge i_clk); while (!cfg_bus.ready);
            sb.write_reg(writes[i].index, writes[i].data);
            @(negedge i_clk);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic pix_event_t fixed_event(logic [CSO_OP_W-1:0] op, int x, int y,
                                               logic [CSO_COLOR_W-1:0] r,
                                               logic [CSO_COLOR_W-1:0] g,
                                               logic [CSO_COLOR_W-1:0] b);
        return '{op, CSO_POS_W'(x), CSO_POS_W'(y), r, g, b};
    endfunction

    // Any opcode with fully random content; the fields a move ignores still toggle.
    function automatic pix_event_t random_event(logic [CSO_OP_W-1:0] op);
        return '{op, CSO_POS_W'($urandom_range(0, POS_MAX)), CSO_POS_W'($urandom_range(0, POS_MAX)),
                 CSO_COLOR_W'($urandom_range(0, 255)), CSO_COLOR_W'($urandom_range(0, 255)),
                 CSO_COLOR_W'($urandom_range(0, 255))};
    endfunction

    // Frame dimension: mostly in the usual range, often one of the corner values around
    // the clamp margins, the small-frame saturation and the large-frame cap.
    function automatic logic [CSO_DIM_W-1:0] random_dim();
        int corners [13] = '{0, 5, 7, 8, 10, 11, 16, 17, 1023, 1024, 1031, 1034, 2047};
        if ($urandom_range(0, 99) < 30) begin
            return CSO_DIM_W'(corners[$urandom_range(0, 12)]);
        end
        return CSO_DIM_W'($urandom_range(16, 1024));
    endfunction

    initial begin
        pix_event_t ev;
        cfg_write_t writes [$];
        logic [CSO_DIM_W-1:0] en_data;
        logic [CSO_OP_W-1:0]  dir;
        int stop_at;
        int phase_left;
        int burst;
        int pick;

        i_rst_n          = 1'b0;
        pix_in.valid     = 1'b0;
        pix_in.opcode    = OP_PIXEL;
        pix_in.pixel_x   = '0;
        pix_in.pixel_y   = '0;
        pix_in.red_in    = '0;
        pix_in.green_in  = '0;
        pix_in.blue_in   = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = CFG_CURSOR_ENABLE;
        cfg_bus.data     = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. At reset the cursor is disabled: moves must not move it and a
        // pixel on a black cell of the arrow passes through; an unused opcode gives zeros.
        send_event(fixed_event(OP_RIGHT, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(fixed_event(OP_DOWN, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(fixed_event(OP_PIXEL, 5, 0, 8'hFF, 8'h00, 8'hA5));
        send_event(fixed_event(OP_UNUSED_HI, POS_MAX, POS_MAX, 8'hFF, 8'hFF, 8'hFF));
        settle();

        // Enable with every data bit set (only bit 0 counts) and the smallest usual frame.
        apply_config('{'{CFG_CURSOR_ENABLE, 11'h7FF}, '{CFG_FRAME_WIDTH, 11'd16},
                       '{CFG_FRAME_HEIGHT, 11'd16}});
        send_event(fixed_event(OP_PIXEL, 5, 0, 8'h12, 8'h34, 8'h56));     // black cell
        send_event(fixed_event(OP_PIXEL, 5, 1, 8'h12, 8'h34, 8'h56));     // white cell
        send_event(fixed_event(OP_PIXEL, 0, 0, 8'h81, 8'h42, 8'h24));     // clear cell
        send_event(fixed_event(OP_DOWN, 0, 0, 8'h00, 8'h00, 8'h00));      // clamps at 5
        send_event(fixed_event(OP_DOWN, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(fixed_event(OP_RIGHT, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(fixed_event(OP_RIGHT, 0, 0, 8'h00, 8'h00, 8'h00));     // clamps at 8
        send_event(fixed_event(OP_PIXEL, 13, 5, 8'h77, 8'h88, 8'h99));
        send_event(fixed_event(OP_PIXEL, 16, 5, 8'h77, 8'h88, 8'h99));    // outside frame
        send_event(fixed_event(OP_PIXEL, POS_MAX, POS_MAX, 8'hFF, 8'hFF, 8'hFF));
        send_event(fixed_event(OP_UNUSED_LO, 0, 0, 8'hFF, 8'hFF, 8'hFF));
        send_event(fixed_event(OP_LEFT, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(fixed_event(OP_LEFT, 0, 0, 8'h00, 8'h00, 8'h00));      // clamps at 0
        send_event(fixed_event(OP_UP, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(fixed_event(OP_UP, 0, 0, 8'h00, 8'h00, 8'h00));
        settle();

        // A frame smaller than the margins: the high clamp saturates at zero.
        apply_config('{'{CFG_FRAME_WIDTH, 11'd5}, '{CFG_FRAME_HEIGHT, 11'd3}});
        send_event(fixed_event(OP_DOWN, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(fixed_event(OP_RIGHT, 0, 0, 8'h00, 8'h00, 8'h00));
        settle();

        // The largest frame the registers hold.
        apply_config('{'{CFG_FRAME_WIDTH, 11'h7FF}, '{CFG_FRAME_HEIGHT, 11'h7FF}});
        send_event(fixed_event(OP_RIGHT, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(fixed_event(OP_DOWN, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(fixed_event(OP_PIXEL, 11, 6, 8'h5A, 8'hA5, 8'h3C));
        settle();

        // Disabled again: moves hold, overlay is off. Then a frame that leaves the cursor
        // beyond the clamp, so a move to the right pulls it back.
        apply_config('{'{CFG_CURSOR_ENABLE, 11'h7FE}, '{CFG_UNUSED_INDEX, 11'h155}});
        send_event(fixed_event(OP_LEFT, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(fixed_event(OP_PIXEL, 11, 6, 8'h5A, 8'hA5, 8'h3C));
        settle();
        apply_config('{'{CFG_CURSOR_ENABLE, 11'd1}, '{CFG_FRAME_WIDTH, 11'd10}});
        send_event(fixed_event(OP_RIGHT, 0, 0, 8'h00, 8'h00, 8'h00));

        // Random part, in phases. Each phase starts from an idle block with new register
        // values and its own idling mode. Most events are pixels around the cursor, so the
        // overlay is exercised on every cell; bursts of one move walk the cursor far enough
        // to reach the clamps of large frames.
        stop_at = events_sent + RANDOM_EVENTS;
        while (events_sent < stop_at) begin
            settle();
            en_data = CSO_DIM_W'($urandom_range(0, 2 ** CSO_DIM_W - 1));
            en_data[0] = ($urandom_range(0, 99) < 85);
            writes = '{'{CFG_CURSOR_ENABLE, en_data}, '{CFG_FRAME_WIDTH, random_dim()},
                       '{CFG_FRAME_HEIGHT, random_dim()}};
            if ($urandom_range(0, 99) < 20) begin
                writes.push_back('{CFG_UNUSED_INDEX,
                                   CSO_DIM_W'($urandom_range(0, 2 ** CSO_DIM_W - 1))});
            end
            apply_config(writes);
            gaps_on    = ($urandom_range(0, 3) != 0);
            stalls_on  = ($urandom_range(0, 3) != 0);
            phase_left = $urandom_range(60, 140);
            while (phase_left > 0) begin
                // The tail can begin in the middle of a phase.
                quiet_tail = (stop_at - events_sent <= TAIL_EVENTS);
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    dir   = CSO_OP_W'($urandom_range(OP_UP, OP_RIGHT));
                    burst = $urandom_range(4, 40);
                    repeat (burst) send_event(random_event(dir));
                    phase_left -= burst;
                end else begin
                    if (pick < 22) begin
                        ev = random_event(CSO_OP_W'($urandom_range(OP_UP, OP_RIGHT)));
                    end else if (pick < 27) begin
                        ev = random_event(CSO_OP_W'(OP_RIGHT) + CSO_OP_W'($urandom_range(1, 3)));
                    end else if (pick < 40) begin
                        ev = random_event(OP_PIXEL);
                    end else begin
                        // A pixel in and just around the sprite box.
                        ev = random_event(OP_PIXEL);
                        ev.pixel_x = CSO_POS_W'(sb.cur_col + $urandom_range(0, 20) - 2);
                        ev.pixel_y = CSO_POS_W'(sb.cur_row + $urandom_range(0, 25) - 2);
                    end
                    send_event(ev);
                    phase_left--;
                end
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
